### rtl/mts_pkg.sv
// Shared types, codes and helpers for the multi-timeout supervisor.
// No dependencies.
`timescale 1ns / 1ps

package mts_pkg;

  localparam int NUM_TIMERS = 7;
  localparam int NUM_REGS   = 5;
  localparam int CNT_W      = 26;   // timer count width, also the min output width
  localparam int SEC_W      = 16;   // timeout register width
  localparam int REG_IDX_W  = 3;
  localparam int TID_W      = 3;

  localparam logic [9:0] MS_PER_S = 10'd1000;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [SEC_W-1:0] sec_t;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_START    = 3'd1,
    OP_STOP     = 3'd2,
    OP_STOP_ALL = 3'd3,
    OP_CHECK    = 3'd4
  } op_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_COLD_ACK   = 3'd0,
    REG_SHDN_ACK   = 3'd1,
    REG_IPC_READY  = 3'd2,
    REG_DUMP_IPC   = 3'd3,
    REG_DUMP_READY = 3'd4
  } reg_idx_t;

  // Timer numbering
  localparam logic [TID_W-1:0] T_COLD_ACK   = 3'd0;
  localparam logic [TID_W-1:0] T_SHDN_ACK   = 3'd1;
  localparam logic [TID_W-1:0] T_IPC        = 3'd2;
  localparam logic [TID_W-1:0] T_BUS        = 3'd3;
  localparam logic [TID_W-1:0] T_REBOOT     = 3'd4;
  localparam logic [TID_W-1:0] T_DUMP_IPC   = 3'd5;
  localparam logic [TID_W-1:0] T_DUMP_READY = 3'd6;

  // Action flags raised by a check
  typedef struct packed {
    logic reset_modem;
    logic modem_off;
    logic dump_ipc_error;
    logic fw_ready_timeout_note;
    logic dump_link_error_note;
    logic cold_ack_missing;
    logic shutdown_ack_missing;
    logic nothing_expired;
  } flags_t;

  // Register that feeds each timer's timeout
  function automatic reg_idx_t timer_reg(input logic [TID_W-1:0] id);
    reg_idx_t r;
    case (id)
      T_COLD_ACK:   r = REG_COLD_ACK;
      T_SHDN_ACK:   r = REG_SHDN_ACK;
      T_DUMP_IPC:   r = REG_DUMP_IPC;
      T_DUMP_READY: r = REG_DUMP_READY;
      default:      r = REG_IPC_READY;
    endcase
    return r;
  endfunction

  function automatic cnt_t min2(input cnt_t a, input cnt_t b);
    return (b < a) ? b : a;
  endfunction

endpackage

### rtl/multi_timeout_supervisor.sv
// Multi-timeout supervisor: seven countdown timers, five timeout registers.
// Depends on mts_pkg.
`timescale 1ns / 1ps

// Usage
// - cfg_we/cfg_idx/cfg_wdata write the five timeout registers (seconds).
//   Writes to indexes 5..7 are dropped. Write only while idle.
// - Input channel (in_valid/in_ready) carries one operation per
//   transaction: tick (1 ms), start, stop, stop all, check expiry.
// - Output channel (out_valid/out_ready) returns exactly one result per
//   input transaction: smallest remaining count among armed timers (or
//   none_armed) after the update, plus action flags on a check.
// - Latency: result valid the cycle after the input transaction.
// - Throughput: one transaction per cycle; the timer update and the
//   seven-way minimum both sit between the accept edge and the result
//   register, so nothing limits the rate but the output handshake.
// - Stall: the result register holds until taken; in_ready stays high
//   while the register is empty or is being drained in the same cycle.
// - Reset (rst_n low, synchronous): all timers disarmed, counts and
//   timeout registers cleared, output channel empty.
module multi_timeout_supervisor (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_we,
  input  logic [mts_pkg::REG_IDX_W-1:0] cfg_idx,
  input  logic [mts_pkg::SEC_W-1:0]     cfg_wdata,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    in_operation,
  input  logic [mts_pkg::TID_W-1:0]     in_timer_id,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_none_armed,
  output logic [mts_pkg::CNT_W-1:0]     out_min_remaining_ms,
  output logic                          out_reset_modem,
  output logic                          out_modem_off,
  output logic                          out_dump_ipc_error,
  output logic                          out_fw_ready_timeout_note,
  output logic                          out_dump_link_error_note,
  output logic                          out_cold_ack_missing,
  output logic                          out_shutdown_ack_missing,
  output logic                          out_nothing_expired
);

  localparam int NT = mts_pkg::NUM_TIMERS;

  // Timeout registers
  mts_pkg::sec_t           tmo_r [mts_pkg::NUM_REGS];

  // Timer state
  logic [NT-1:0]           armed_r, armed_nxt;
  mts_pkg::cnt_t           cnt_r   [NT];
  mts_pkg::cnt_t           cnt_nxt [NT];

  // Result register
  logic                    out_valid_r;
  logic                    none_r, none_nxt;
  mts_pkg::cnt_t           min_r, min_nxt;
  mts_pkg::flags_t         flags_r, flags_nxt;

  logic                    accept;
  mts_pkg::op_t            op;
  mts_pkg::sec_t           start_sec;
  logic [25:0]             start_ms;     // 16 x 10 bit product, fits 26 bits
  mts_pkg::cnt_t           start_cnt;
  logic [NT-1:0]           expired;
  logic [NT-1:0]           id_hot;

  // Masked counts and min tree
  mts_pkg::cnt_t           mval [NT];
  mts_pkg::cnt_t           m01, m23, m45, m0123, m456, m_all;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign op       = mts_pkg::op_t'(in_operation);

  // Start value: seconds to ms, saturated at the count range
  assign start_sec = tmo_r[mts_pkg::timer_reg(in_timer_id)];
  assign start_ms  = 26'(start_sec) * 26'(mts_pkg::MS_PER_S);
  assign start_cnt = (start_ms > 26'({mts_pkg::CNT_W{1'b1}})) ?
                     {mts_pkg::CNT_W{1'b1}} : mts_pkg::cnt_t'(start_ms);

  always_comb begin
    for (int i = 0; i < NT; i++) begin
      id_hot[i]  = (in_timer_id == mts_pkg::TID_W'(i));
      expired[i] = armed_r[i] && (cnt_r[i] == '0);
    end
  end

  // Timer update
  always_comb begin
    armed_nxt = armed_r;
    flags_nxt = '0;
    for (int i = 0; i < NT; i++) cnt_nxt[i] = cnt_r[i];
    case (op)
      mts_pkg::OP_TICK: begin
        for (int i = 0; i < NT; i++)
          if (armed_r[i] && cnt_r[i] != '0) cnt_nxt[i] = cnt_r[i] - 1'b1;
      end
      mts_pkg::OP_START: begin
        if (start_sec != '0) begin
          for (int i = 0; i < NT; i++)
            if (id_hot[i]) begin
              cnt_nxt[i]   = start_cnt;
              armed_nxt[i] = 1'b1;
            end
        end
      end
      mts_pkg::OP_STOP: begin
        armed_nxt = armed_r & ~id_hot;   // id 7 matches nothing
      end
      mts_pkg::OP_STOP_ALL: begin
        armed_nxt = '0;
      end
      mts_pkg::OP_CHECK: begin
        armed_nxt = armed_r & ~expired;
        flags_nxt.reset_modem           = expired[mts_pkg::T_COLD_ACK]
                                        | expired[mts_pkg::T_SHDN_ACK]
                                        | expired[mts_pkg::T_IPC]
                                        | expired[mts_pkg::T_BUS]
                                        | expired[mts_pkg::T_REBOOT]
                                        | expired[mts_pkg::T_DUMP_READY];
        flags_nxt.modem_off             = expired[mts_pkg::T_SHDN_ACK];
        flags_nxt.dump_ipc_error        = expired[mts_pkg::T_DUMP_IPC];
        flags_nxt.fw_ready_timeout_note = expired[mts_pkg::T_IPC];
        flags_nxt.dump_link_error_note  = expired[mts_pkg::T_DUMP_READY];
        flags_nxt.cold_ack_missing      = expired[mts_pkg::T_COLD_ACK];
        flags_nxt.shutdown_ack_missing  = expired[mts_pkg::T_SHDN_ACK];
        flags_nxt.nothing_expired       = (expired == '0);
      end
      default: ;   // unused codes: no change
    endcase
  end

  // Smallest count among timers armed after the update; disarmed slots
  // read as all ones, above any reachable count.
  always_comb begin
    for (int i = 0; i < NT; i++)
      mval[i] = armed_nxt[i] ? cnt_nxt[i] : {mts_pkg::CNT_W{1'b1}};
    m01   = mts_pkg::min2(mval[0], mval[1]);
    m23   = mts_pkg::min2(mval[2], mval[3]);
    m45   = mts_pkg::min2(mval[4], mval[5]);
    m0123 = mts_pkg::min2(m01, m23);
    m456  = mts_pkg::min2(m45, mval[6]);
    m_all = mts_pkg::min2(m0123, m456);
    none_nxt = (armed_nxt == '0);
    min_nxt  = none_nxt ? '0 : m_all;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      armed_r     <= '0;
      for (int i = 0; i < NT; i++) cnt_r[i] <= '0;
      for (int r = 0; r < mts_pkg::NUM_REGS; r++) tmo_r[r] <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          mts_pkg::REG_COLD_ACK:   tmo_r[mts_pkg::REG_COLD_ACK]   <= cfg_wdata;
          mts_pkg::REG_SHDN_ACK:   tmo_r[mts_pkg::REG_SHDN_ACK]   <= cfg_wdata;
          mts_pkg::REG_IPC_READY:  tmo_r[mts_pkg::REG_IPC_READY]  <= cfg_wdata;
          mts_pkg::REG_DUMP_IPC:   tmo_r[mts_pkg::REG_DUMP_IPC]   <= cfg_wdata;
          mts_pkg::REG_DUMP_READY: tmo_r[mts_pkg::REG_DUMP_READY] <= cfg_wdata;
          default: ;   // no register there
        endcase
      end
      if (accept) begin
        armed_r <= armed_nxt;
        for (int i = 0; i < NT; i++) cnt_r[i] <= cnt_nxt[i];
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload, loaded with each accepted transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      none_r  <= none_nxt;
      min_r   <= min_nxt;
      flags_r <= flags_nxt;
    end
  end

  assign out_valid                 = out_valid_r;
  assign out_none_armed            = none_r;
  assign out_min_remaining_ms      = min_r;
  assign out_reset_modem           = flags_r.reset_modem;
  assign out_modem_off             = flags_r.modem_off;
  assign out_dump_ipc_error        = flags_r.dump_ipc_error;
  assign out_fw_ready_timeout_note = flags_r.fw_ready_timeout_note;
  assign out_dump_link_error_note  = flags_r.dump_link_error_note;
  assign out_cold_ack_missing      = flags_r.cold_ack_missing;
  assign out_shutdown_ack_missing  = flags_r.shutdown_ack_missing;
  assign out_nothing_expired       = flags_r.nothing_expired;

  // Assertions
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted transaction produced no result");

  a_none_min_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_none_armed |-> out_min_remaining_ms == '0)
    else $error("nonzero minimum with no timer armed");

  a_nothing_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_nothing_expired |-> !(out_reset_modem || out_dump_ipc_error))
    else $error("nothing_expired raised together with an action");

  a_stop_all_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_operation == mts_pkg::OP_STOP_ALL |=> out_none_armed)
    else $error("timer still armed after stop all");

endmodule

### tb/testbench.sv
// Self-checking testbench for multi_timeout_supervisor: a directed table, then random phases.
// Depends on mts_pkg and the multi_timeout_supervisor RTL. Needs no files and no arguments.
`timescale 1ns / 1ps

module testbench;
  import mts_pkg::*;

  // Operation codes the block decodes as no-ops, and one timer id past the
  // last timer
  localparam logic [2:0] OP_RSVD_5 = 3'd5;
  localparam logic [2:0] OP_RSVD_7 = 3'd7;
  localparam logic [TID_W-1:0] T_NONE = 3'd7;

  localparam longint unsigned MS_PER_SEC = 1000;
  localparam longint unsigned CNT_MAX    = (64'd1 << CNT_W) - 1;

  // Random part: items per phase; the first phase adds one long tick run
  localparam int ITEMS_PER_PHASE = 75;
  // Timeout watchdog, far above the slowest expected run
  localparam int CYCLE_LIMIT = 50_000;

  // Expected content of one result transaction
  typedef struct {
    logic   none_armed;
    cnt_t   min_ms;
    flags_t flags;
  } outcome_t;

  // One line of the directed table: an item, sent reps times, and optionally
  // the expected result typed in by hand
  typedef struct {
    logic [2:0]       op;
    logic [TID_W-1:0] id;
    int               reps;
    bit               typed;
    outcome_t         want;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_idx = '0;
  logic [SEC_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [2:0]           in_operation = OP_TICK;
  logic [TID_W-1:0]     in_timer_id = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_none_armed;
  cnt_t                 out_min_remaining_ms;
  logic                 out_reset_modem;
  logic                 out_modem_off;
  logic                 out_dump_ipc_error;
  logic                 out_fw_ready_timeout_note;
  logic                 out_dump_link_error_note;
  logic                 out_cold_ack_missing;
  logic                 out_shutdown_ack_missing;
  logic                 out_nothing_expired;

  // Timer supervision model state, at its reset values
  sec_t                  tmo_s [NUM_REGS] = '{default: '0};
  logic [NUM_TIMERS-1:0] armed = '0;
  cnt_t                  left_ms [NUM_TIMERS] = '{default: '0};
  // Register that feeds each timer's timeout; ipc, bus and reboot share one
  reg_idx_t              src_reg [NUM_TIMERS] = '{REG_COLD_ACK, REG_SHDN_ACK,
                                                  REG_IPC_READY, REG_IPC_READY,
                                                  REG_IPC_READY, REG_DUMP_IPC,
                                                  REG_DUMP_READY};

  outcome_t  awaited_results [$];
  stim_row_t script [$];
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        errors = 0;
  int        cycles = 0;

  multi_timeout_supervisor i_dut (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .cfg_we                    (cfg_we),
    .cfg_idx                   (cfg_idx),
    .cfg_wdata                 (cfg_wdata),
    .in_valid                  (in_valid),
    .in_ready                  (in_ready),
    .in_operation              (in_operation),
    .in_timer_id               (in_timer_id),
    .out_valid                 (out_valid),
    .out_ready                 (out_ready),
    .out_none_armed            (out_none_armed),
    .out_min_remaining_ms      (out_min_remaining_ms),
    .out_reset_modem           (out_reset_modem),
    .out_modem_off             (out_modem_off),
    .out_dump_ipc_error        (out_dump_ipc_error),
    .out_fw_ready_timeout_note (out_fw_ready_timeout_note),
    .out_dump_link_error_note  (out_dump_link_error_note),
    .out_cold_ack_missing      (out_cold_ack_missing),
    .out_shutdown_ack_missing  (out_shutdown_ack_missing),
    .out_nothing_expired       (out_nothing_expired)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("[multi_timeout_supervisor] ERROR");
      $finish;
    end
  end

  // Applies one item to the timer model and returns the result it yields.
  // The minimum is taken after the update, over armed timers only.
  function automatic outcome_t supervise_step(input logic [2:0] op,
                                              input logic [TID_W-1:0] id);
    outcome_t              r;
    logic [NUM_TIMERS-1:0] fired;
    longint unsigned       ms;
    bit                    any;
    r.none_armed = 1'b0;
    r.min_ms     = '0;
    r.flags      = '0;
    fired        = '0;
    any          = 1'b0;
    case (op)
      OP_TICK: begin
        // one millisecond; expired timers sit at zero
        for (int i = 0; i < NUM_TIMERS; i++)
          if (armed[i] && left_ms[i] != 0) left_ms[i] = left_ms[i] - 1'b1;
      end
      OP_START: begin
        // zero timeout leaves the timer as it was, armed or not
        if (id < NUM_TIMERS) begin
          ms = longint'(tmo_s[src_reg[id]]) * MS_PER_SEC;
          if (ms != 0) begin
            if (ms > CNT_MAX) ms = CNT_MAX;
            left_ms[id] = cnt_t'(ms);
            armed[id]   = 1'b1;
          end
        end
      end
      OP_STOP: begin
        if (id < NUM_TIMERS) armed[id] = 1'b0;
      end
      OP_STOP_ALL: armed = '0;
      OP_CHECK: begin
        for (int i = 0; i < NUM_TIMERS; i++) fired[i] = armed[i] && left_ms[i] == 0;
        armed = armed & ~fired;
        // every expiry but the dump IPC timer forces a modem reset
        r.flags.reset_modem           = fired[T_COLD_ACK] | fired[T_SHDN_ACK] |
                                        fired[T_IPC] | fired[T_BUS] |
                                        fired[T_REBOOT] | fired[T_DUMP_READY];
        r.flags.modem_off             = fired[T_SHDN_ACK];
        r.flags.dump_ipc_error        = fired[T_DUMP_IPC];
        r.flags.fw_ready_timeout_note = fired[T_IPC];
        r.flags.dump_link_error_note  = fired[T_DUMP_READY];
        r.flags.cold_ack_missing      = fired[T_COLD_ACK];
        r.flags.shutdown_ack_missing  = fired[T_SHDN_ACK];
        r.flags.nothing_expired       = (fired == '0);
      end
      default: ;  // reserved codes change nothing
    endcase
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (armed[i]) begin
        if (!any || left_ms[i] < r.min_ms) r.min_ms = left_ms[i];
        any = 1'b1;
      end
    end
    r.none_armed = !any;
    return r;
  endfunction

  // Table line checked against the timer model
  function automatic stim_row_t plain(input logic [2:0] op, input logic [TID_W-1:0] id,
                                      input int reps);
    stim_row_t s;
    s.op   = op;
    s.id   = id;
    s.reps = reps;
    s.typed = 1'b0;
    s.want.none_armed = 1'b0;
    s.want.min_ms     = '0;
    s.want.flags      = '0;
    return s;
  endfunction

  // Table line with its result typed in; no action flag but nothing_expired
  function automatic stim_row_t known(input logic [2:0] op, input logic [TID_W-1:0] id,
                                      input logic none, input cnt_t min_ms,
                                      input logic quiet);
    stim_row_t s;
    s = plain(op, id, 1);
    s.typed = 1'b1;
    s.want.none_armed = none;
    s.want.min_ms     = min_ms;
    s.want.flags.nothing_expired = quiet;
    return s;
  endfunction

  function automatic sec_t pick_timeout();
    int roll;
    roll = $urandom_range(99);
    // mostly short timeouts; zero and the largest value stay in the mix
    if (roll < 10) return '0;
    if (roll < 50) return sec_t'(1);
    if (roll < 80) return sec_t'(2);
    if (roll < 90) return '1;
    return sec_t'($urandom);
  endfunction

  // Sends one transaction, with random idle cycles first, and records its
  // expected result once the block takes it
  task automatic send_item(input logic [2:0] op, input logic [TID_W-1:0] id,
                           input bit typed, input outcome_t want);
    outcome_t pred;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_timer_id  <= id;
    do @(posedge clk); while (!in_ready);
    pred = supervise_step(op, id);
    awaited_results.push_back(typed ? want : pred);
  endtask

  // Holds the sender off until every outstanding result has been taken.
  // Always waits on the clock before returning, so in_valid never flips twice in a step.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  // Leaves cfg_we high; the caller lowers it after the last write
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input sec_t val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx < NUM_REGS) tmo_s[idx] = val;
  endtask

  // Result side: random backpressure, at the rate of the current phase
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic check_field(input string name, input cnt_t want, input cnt_t got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  task automatic check_bit(input string name, input logic want, input logic got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Scoreboard: each result transaction against the oldest expectation
  always @(posedge clk) begin : result_check
    outcome_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        $error("result transaction with no item outstanding");
        errors++;
      end else begin
        want = awaited_results.pop_front();
        check_bit("none_armed", want.none_armed, out_none_armed);
        check_field("min_remaining_ms", want.min_ms, out_min_remaining_ms);
        check_bit("reset_modem", want.flags.reset_modem, out_reset_modem);
        check_bit("modem_off", want.flags.modem_off, out_modem_off);
        check_bit("dump_ipc_error", want.flags.dump_ipc_error, out_dump_ipc_error);
        check_bit("fw_ready_timeout_note", want.flags.fw_ready_timeout_note,
                  out_fw_ready_timeout_note);
        check_bit("dump_link_error_note", want.flags.dump_link_error_note,
                  out_dump_link_error_note);
        check_bit("cold_ack_missing", want.flags.cold_ack_missing,
                  out_cold_ack_missing);
        check_bit("shutdown_ack_missing", want.flags.shutdown_ack_missing,
                  out_shutdown_ack_missing);
        check_bit("nothing_expired", want.flags.nothing_expired,
                  out_nothing_expired);
      end
    end
  end

  initial begin : stimulus
    outcome_t   blank;
    logic [2:0] op;
    logic [TID_W-1:0] id;
    int         sent;
    int         roll;
    blank.none_armed = 1'b0;
    blank.min_ms     = '0;
    blank.flags      = '0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed setup: cold ack at the largest timeout, shared ipc register
    // left at zero so starts of timers 2..4 are dropped
    write_reg(REG_COLD_ACK, '1);
    write_reg(REG_SHDN_ACK, sec_t'(1));
    write_reg(REG_IPC_READY, '0);
    write_reg(REG_DUMP_IPC, sec_t'(2));
    write_reg(REG_DUMP_READY, sec_t'(3));
    cfg_we <= 1'b0;

    // Nothing armed yet, then arming, ignored ids and codes, rearm, stops,
    // a check with every armed timer still running, and stops one by one
    script.push_back(known(OP_TICK, T_COLD_ACK, 1'b1, '0, 1'b0));
    script.push_back(known(OP_CHECK, T_COLD_ACK, 1'b1, '0, 1'b1));
    script.push_back(known(OP_START, T_IPC, 1'b1, '0, 1'b0));
    script.push_back(known(OP_START, T_COLD_ACK, 1'b0, cnt_t'(65535000), 1'b0));
    script.push_back(known(OP_START, T_SHDN_ACK, 1'b0, cnt_t'(1000), 1'b0));
    script.push_back(plain(OP_START, T_NONE, 1));
    script.push_back(plain(OP_STOP, T_NONE, 1));
    script.push_back(plain(OP_RSVD_5, T_BUS, 1));
    script.push_back(plain(OP_RSVD_7, T_DUMP_READY, 1));
    script.push_back(plain(OP_TICK, T_COLD_ACK, 1));
    script.push_back(plain(OP_START, T_SHDN_ACK, 1));
    script.push_back(plain(OP_STOP, T_COLD_ACK, 1));
    script.push_back(known(OP_STOP_ALL, T_COLD_ACK, 1'b1, '0, 1'b0));
    script.push_back(known(OP_CHECK, T_COLD_ACK, 1'b1, '0, 1'b1));
    script.push_back(plain(OP_START, T_COLD_ACK, 1));
    script.push_back(plain(OP_START, T_SHDN_ACK, 1));
    script.push_back(plain(OP_START, T_DUMP_IPC, 1));
    script.push_back(plain(OP_START, T_DUMP_READY, 1));
    script.push_back(plain(OP_TICK, T_REBOOT, 5));
    script.push_back(plain(OP_START, T_BUS, 1));
    script.push_back(plain(OP_CHECK, T_COLD_ACK, 1));
    script.push_back(plain(OP_STOP, T_SHDN_ACK, 1));
    script.push_back(plain(OP_STOP, T_DUMP_IPC, 1));
    script.push_back(plain(OP_STOP, T_DUMP_READY, 1));
    script.push_back(known(OP_STOP, T_COLD_ACK, 1'b1, '0, 1'b0));

    foreach (script[k])
      repeat (script[k].reps) send_item(script[k].op, script[k].id, script[k].typed,
                                        script[k].want);

    // Random phases: no idling, sender idle, receiver stalling, both.
    // Each phase starts idle and reprograms the timeouts.
    for (int phase = 0; phase < 4; phase++) begin
      drain();
      send_idle_pct  = (phase == 1) ? 53 : (phase == 3) ? 28 : 0;
      recv_stall_pct = (phase == 2) ? 53 : (phase == 3) ? 28 : 0;
      // first phase: every timeout one second, so every timer can expire
      for (int r = 0; r < NUM_REGS; r++)
        write_reg(REG_IDX_W'(r), (phase == 0) ? sec_t'(1) : pick_timeout());
      // indexes past the last register must be dropped
      if (phase == 1)
        for (int r = NUM_REGS; r < (1 << REG_IDX_W); r++)
          write_reg(REG_IDX_W'(r), sec_t'($urandom));
      cfg_we <= 1'b0;

      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        roll = $urandom_range(99);
        id = ($urandom_range(15) == 0) ? T_NONE : TID_W'($urandom_range(NUM_TIMERS - 1));
        if (roll < 2) begin
          drain();
        end else begin
          roll = $urandom_range(99);
          if (roll < 35)      op = OP_TICK;
          else if (roll < 60) op = OP_START;
          else if (roll < 68) op = OP_STOP;
          else if (roll < 71) op = OP_STOP_ALL;
          else if (roll < 95) op = OP_CHECK;
          else                op = 3'($urandom_range(OP_RSVD_5, OP_RSVD_7));
          send_item(op, id, 1'b0, blank);
          sent++;
          // first phase, halfway: one long tick run carries armed timers
          // to and past zero, so the checks that follow see expiries
          if (phase == 0 && sent == ITEMS_PER_PHASE / 2)
            repeat ($urandom_range(990, 1010)) send_item(OP_TICK, id, 1'b0, blank);
        end
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("[multi_timeout_supervisor] OK");
    end else begin
      $display("[multi_timeout_supervisor] ERROR");
    end
    $finish;
  end

endmodule
